>>> sv/cidt_pkg.sv
// ----------------------------------------------------------------------------
// cidt_pkg
// Shared codes, widths and constants for the card identifier table.
// ----------------------------------------------------------------------------
package cidt_pkg;

    localparam int OP_W     = 2;
    localparam int CARD_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_NOT_FOUND   = 2'd1,
        ST_ALREADY     = 2'd2,
        ST_TABLE_FULL  = 2'd3
    } status_t;

    localparam logic [CARD_W-1:0] DEMO_CARD_ID = 32'hDEAD_BEEF;

endpackage

>>> sv/card_id_table_match_insert_delete.sv
// ----------------------------------------------------------------------------
// card_id_table_match_insert_delete
// Card identifier table with find, first-free add and delete per item.
//
//   channel  dir  fields (low bit up)                      notes
//   s_axis   in   tdata: operation[1:0], card_id[33:2]     40-bit tdata
//   m_axis   out  tdata: slot[3:0], status[5:4]            8-bit tdata
//
// One item per cycle while the result is not stalled: an input register feeds
// a parallel compare over all slots and two priority encoders, and the result
// register takes the answer. The result is valid once its item has moved on
// into the result register. The table is updated at the edge an item moves
// into the result register, so the next item sees it.
// Reset leaves slot 0 holding the demo identifier and all others free.
// A stalled result holds both registers once the input register is full; the input side stops only then.
// ----------------------------------------------------------------------------
module card_id_table_match_insert_delete #(
    parameter int NUM_SLOTS = 16,
    parameter int ID_BYTES  = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [cidt_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // operation, card_id
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [cidt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata   // slot, status
);
    import cidt_pkg::*;

    localparam int ID_W  = ((ID_BYTES >= 4) ? 4 : ID_BYTES) * 8;
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [ID_W-1:0] RESET_ID = DEMO_CARD_ID[CARD_W-1 -: ID_W];

    // input register
    logic              in_valid_reg;
    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   key_reg;

    // result register
    logic                out_valid_reg;
    logic [SLOT_W-1:0]   slot_reg;
    status_t             status_reg;

    // table
    logic [NUM_SLOTS-1:0] slot_valid_reg;
    logic [ID_W-1:0]      slot_id_reg [NUM_SLOTS];

    logic              advance;
    logic              hit_found;
    logic [IDX_W-1:0]  hit_idx;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic              do_add;
    logic              do_delete;
    logic [SLOT_W-1:0] slot_next;
    status_t           status_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - SLOT_W - STATUS_W){1'b0}}, status_reg, slot_reg};

    // lowest matching valid slot and lowest free slot
    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i] && (slot_id_reg[i] == key_reg))
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
            if (!slot_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        do_add      = 1'b0;
        do_delete   = 1'b0;
        slot_next   = '0;
        status_next = ST_NOT_FOUND;
        unique case (op_reg)
            OP_ADD:
            begin
                if (hit_found)
                begin
                    status_next = ST_ALREADY;
                end
                else if (!free_found)
                begin
                    status_next = ST_TABLE_FULL;
                end
                else
                begin
                    do_add      = 1'b1;
                    slot_next   = SLOT_W'(free_idx);
                    status_next = ST_OK;
                end
            end
            OP_DELETE:
            begin
                if (hit_found)
                begin
                    do_delete   = 1'b1;
                    slot_next   = SLOT_W'(hit_idx);
                    status_next = ST_OK;
                end
            end
            default:
            begin
                // find; the unused code also reads as find
                if (hit_found)
                begin
                    slot_next   = SLOT_W'(hit_idx);
                    status_next = ST_OK;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg  <= s_axis_tdata[OP_W-1:0];
            key_reg <= s_axis_tdata[OP_W+CARD_W-1 -: ID_W];
        end
        if (advance)
        begin
            slot_reg   <= slot_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= NUM_SLOTS'(1);
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_id_reg[i] <= (i == 0) ? RESET_ID : '0;
            end
        end
        else if (advance)
        begin
            if (do_add)
            begin
                slot_valid_reg[free_idx] <= 1'b1;
                slot_id_reg[free_idx]    <= key_reg;
            end
            if (do_delete)
            begin
                slot_valid_reg[hit_idx] <= 1'b0;
                slot_id_reg[hit_idx]    <= '0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && do_add) |=> slot_valid_reg[$past(free_idx)])
        else $error("added slot not marked valid");

    a_delete_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && do_delete) |=> !slot_valid_reg[$past(hit_idx)])
        else $error("deleted slot still valid");

    a_not_ok_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |-> (slot_reg == '0))
        else $error("slot nonzero on failed operation");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
